@@ rtl/cnv_ss_pkg.sv @@
`default_nettype none

package cnv_ss_pkg;

  localparam int unsigned CurWidth   = 14;
  localparam int unsigned MvWidth    = 15;
  localparam int unsigned StepWidth  = 10;
  localparam int unsigned TickWidth  = 6;
  localparam int unsigned OpWidth    = 3;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 15;
  localparam int unsigned InDataWidth  = 16;
  localparam int unsigned OutDataWidth = 56;

  localparam logic [CurWidth-1:0]  TripResetMa   = 14'd800;
  localparam logic [MvWidth-1:0]   VoutMaxResetMv = 15'd22800;
  localparam logic [StepWidth-1:0] PresetStepReset = 10'd100;
  localparam logic [StepWidth-1:0] RampStepReset   = 10'd5;
  localparam logic [TickWidth-1:0] TickDivideReset = 6'd20;

  typedef enum logic [1:0] {
    MODE_STANDBY = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_FAULT   = 2'd2
  } mode_t;

  typedef enum logic [OpWidth-1:0] {
    OP_CURRENT = 3'd0,
    OP_TICK    = 3'd1,
    OP_MODE    = 3'd2,
    OP_ADD     = 3'd3,
    OP_REDUCE  = 3'd4,
    OP_SET     = 3'd5
  } op_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_TRIP_CURRENT = 3'd0,
    REG_VOUT_MAX     = 3'd1,
    REG_PRESET_STEP  = 3'd2,
    REG_RAMP_STEP    = 3'd3,
    REG_TICK_DIVIDE  = 3'd4
  } reg_idx_t;

endpackage

`default_nettype wire

@@ rtl/converter_supervisor_soft_start_core.sv @@
`default_nettype none

// Soft-start supervisor for a step-down converter with an overcurrent latch.
// Each input transaction carries one event (current sample, PWM tick, mode
// click, add held, reduce held, set click) and yields exactly one result
// transaction carrying the mode, the preset, the committed reference, the
// soft-start ramp and three flags: output_enable, control_strobe (this tick
// is a control update while running) and clear_controller (the mode has just
// changed, so the external regulator must drop its state and duty). An event
// is captured in an input register, evaluated against the supervisor state
// by compares and adds only, and the result lands in an output register
// while the state registers update. The block takes one event per clock
// cycle; an event passes from the input register to the output register,
// and a stalled output holds the pipeline. Configuration writes take effect
// at once and are meant to be made only while the block is idle; indexes
// beyond the last register are accepted and ignored.
module converter_supervisor_soft_start_core
  import cnv_ss_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  // event input
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [InDataWidth-1:0]  s_tdata,  // [13:0] current_ma, [15:14] zero
  input  wire logic [OpWidth-1:0]      s_tuser,  // [2:0] operation
  // result output
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [OutDataWidth-1:0]      m_tdata,  // [1:0] mode, [16:2] preset_mv,
                                                 // [31:17] reference_mv, [46:32] ramp_mv,
                                                 // [47] output_enable, [48] control_strobe,
                                                 // [49] clear_controller, [55:50] zero
  // configuration write
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index,
  input  wire logic [CfgDataWidth-1:0] cfg_data
);

  // configuration registers
  logic [CurWidth-1:0]  trip_current_ma;
  logic [MvWidth-1:0]   vout_max_mv;
  logic [StepWidth-1:0] preset_step_mv;
  logic [StepWidth-1:0] ramp_step_mv;
  logic [TickWidth-1:0] tick_divide;

  // supervisor state
  mode_t                mode_reg, mode_next;
  logic [MvWidth-1:0]   preset_reg, preset_next;
  logic [MvWidth-1:0]   reference_reg, reference_next;
  logic [MvWidth-1:0]   ramp_reg, ramp_next;
  logic [TickWidth-1:0] tick_count, tick_count_next;
  logic                 strobe_next, clear_next;

  // input register
  logic                 in_valid;
  logic [OpWidth-1:0]   op_q;
  logic [CurWidth-1:0]  cur_q;

  logic advance;

  // Move the event on whenever the result register is free or being taken.
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trip_current_ma <= TripResetMa;
      vout_max_mv     <= VoutMaxResetMv;
      preset_step_mv  <= PresetStepReset;
      ramp_step_mv    <= RampStepReset;
      tick_divide     <= TickDivideReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TRIP_CURRENT: trip_current_ma <= cfg_data[CurWidth-1:0];
        REG_VOUT_MAX:     vout_max_mv     <= cfg_data[MvWidth-1:0];
        REG_PRESET_STEP:  preset_step_mv  <= cfg_data[StepWidth-1:0];
        REG_RAMP_STEP:    ramp_step_mv    <= cfg_data[StepWidth-1:0];
        REG_TICK_DIVIDE:  tick_divide     <= cfg_data[TickWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q  <= s_tuser;
      cur_q <= s_tdata[CurWidth-1:0];
    end
  end

  // Event evaluation: compares and adds only.
  logic                 running;
  logic [MvWidth:0]     preset_sum;
  logic [MvWidth-1:0]   preset_adj;
  logic [MvWidth-1:0]   preset_step_ext, ramp_step_ext;
  logic [MvWidth:0]     ramp_sum;
  logic [MvWidth-1:0]   ramp_up, ramp_down_raw, ramp_down;
  logic [TickWidth:0]   tick_inc;

  always_comb begin
    running         = (mode_reg == MODE_RUNNING);
    preset_step_ext = {{(MvWidth-StepWidth){1'b0}}, preset_step_mv};
    ramp_step_ext   = {{(MvWidth-StepWidth){1'b0}}, ramp_step_mv};

    preset_sum = {1'b0, preset_reg} + {1'b0, preset_step_ext};

    // Ramp towards the reference, never overshooting it.
    ramp_sum = {1'b0, ramp_reg} + {1'b0, ramp_step_ext};
    ramp_up  = (ramp_sum > {1'b0, reference_reg}) ? reference_reg : ramp_sum[MvWidth-1:0];
    ramp_down_raw = (ramp_reg >= ramp_step_ext) ? (ramp_reg - ramp_step_ext) : '0;
    ramp_down = (ramp_down_raw < reference_reg) ? reference_reg : ramp_down_raw;

    tick_inc = {1'b0, tick_count} + {{TickWidth{1'b0}}, 1'b1};

    mode_next       = mode_reg;
    preset_next     = preset_reg;
    reference_next  = reference_reg;
    ramp_next       = ramp_reg;
    tick_count_next = tick_count;
    strobe_next     = 1'b0;
    clear_next      = 1'b0;
    preset_adj      = preset_reg;

    unique case (op_q)
      OP_CURRENT: begin
        // Latch the fault and drop every setpoint.
        if (running && (cur_q >= trip_current_ma)) begin
          mode_next      = MODE_FAULT;
          preset_next    = '0;
          reference_next = '0;
          ramp_next      = '0;
          clear_next     = 1'b1;
        end
      end
      OP_TICK: begin
        if (tick_inc < {1'b0, tick_divide}) begin
          tick_count_next = tick_inc[TickWidth-1:0];
        end else begin
          tick_count_next = '0;
          if (running) begin
            strobe_next = 1'b1;
            if (ramp_reg < reference_reg) begin
              ramp_next = ramp_up;
            end else if (ramp_reg > reference_reg) begin
              ramp_next = ramp_down;
            end
          end
        end
      end
      OP_MODE: begin
        clear_next = 1'b1;
        mode_next  = MODE_RUNNING;
        ramp_next  = '0;
        if (running) begin
          mode_next = MODE_STANDBY;
        end
        if (running || (mode_reg == MODE_FAULT)) begin
          preset_next    = '0;
          reference_next = '0;
        end
      end
      OP_ADD, OP_REDUCE, OP_SET: begin
        if (running) begin
          if (op_q == OP_ADD) begin
            preset_adj = (preset_sum > {1'b0, vout_max_mv}) ?
                         vout_max_mv : preset_sum[MvWidth-1:0];
          end else if (op_q == OP_REDUCE) begin
            preset_adj = (preset_reg >= preset_step_ext) ? (preset_reg - preset_step_ext) : '0;
            if (preset_adj > vout_max_mv) preset_adj = vout_max_mv;
          end else begin
            if (preset_adj > vout_max_mv) preset_adj = vout_max_mv;
          end
          preset_next = preset_adj;
          if (op_q == OP_SET) begin
            // Commit the (clamped) preset as the new reference.
            reference_next = (preset_reg > vout_max_mv) ? vout_max_mv : preset_reg;
          end else begin
            reference_next = (reference_reg > vout_max_mv) ? vout_max_mv : reference_reg;
          end
        end
      end
      default: ;
    endcase
  end

  // State and result update when the event leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= MODE_STANDBY;
      preset_reg    <= '0;
      reference_reg <= '0;
      ramp_reg      <= '0;
      tick_count    <= '0;
    end else if (in_valid && advance) begin
      mode_reg      <= mode_next;
      preset_reg    <= preset_next;
      reference_reg <= reference_next;
      ramp_reg      <= ramp_next;
      tick_count    <= tick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      m_tdata <= {6'b0, clear_next, strobe_next, (mode_next == MODE_RUNNING),
                  ramp_next, reference_next, preset_next, mode_next};
    end
  end

  // A latched fault always carries zero setpoints.
  assert property (@(posedge clk) disable iff (rst)
    (mode_reg == MODE_FAULT) |-> (preset_reg == '0 && reference_reg == '0 && ramp_reg == '0))
    else $error("fault latched with non-zero setpoint");

  // A control strobe is only issued while running.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[48]) |-> (m_tdata[1:0] == MODE_RUNNING && m_tdata[47]))
    else $error("control strobe outside running");

  // The tick counter wraps before reaching the all-ones code.
  assert property (@(posedge clk) disable iff (rst)
    tick_count != {TickWidth{1'b1}})
    else $error("tick counter out of range");

  // A held event is not lost while the result register is stalled.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(op_q) && $stable(mode_reg)))
    else $error("stalled event dropped or state moved");

endmodule

`default_nettype wire

@@ bench/converter_supervisor_soft_start_core_test.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the soft-start supervisor. Each event goes in on the
// slave-side stream and advances a behavioural copy of the supervisor state;
// the outcome it predicts is queued and compared field by field with the
// result transaction that comes out on the master side.
module converter_supervisor_soft_start_core_test;
  import cnv_ss_pkg::*;

  // Operation codes the block must treat as no-ops
  localparam logic [OpWidth-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OpWidth-1:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned        REPORT_LIMIT = 10;

  typedef struct packed {
    mode_t              mode;
    logic [MvWidth-1:0] preset_mv;
    logic [MvWidth-1:0] reference_mv;
    logic [MvWidth-1:0] ramp_mv;
    logic               output_enable;
    logic               control_strobe;
    logic               clear_controller;
  } supervisor_outcome_t;

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [InDataWidth-1:0]  s_tdata;   // [13:0] current_ma, [15:14] zero
  logic [OpWidth-1:0]      s_tuser;   // [2:0] operation
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OutDataWidth-1:0] m_tdata;   // [1:0] mode, [16:2] preset_mv, [31:17] reference_mv,
                                      // [46:32] ramp_mv, [47] output_enable,
                                      // [48] control_strobe, [49] clear_controller
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CfgIdxWidth-1:0]  cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  // Register copies held by the bench
  int unsigned trip_ma;
  int unsigned ceiling_mv;
  int unsigned preset_step;
  int unsigned ramp_step;
  int unsigned tick_div;

  // Supervisor state as the bench sees it
  mode_t       sup_mode;
  int unsigned preset_mv;
  int unsigned reference_mv;
  int unsigned ramp_mv;
  int unsigned tick_count;

  supervisor_outcome_t supervisor_outcomes[$];

  bit          idle_on;
  int unsigned errors;
  int unsigned events_sent;
  int unsigned outcomes_checked;
  int unsigned faults_latched;
  int unsigned control_updates;
  int unsigned settings_used;

  converter_supervisor_soft_start_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run, gaps and stalls included
  initial begin
    #5_000_000;
    $display("[converter_supervisor_soft_start_core] ERROR");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Behavioural supervisor
  // ------------------------------------------------------------------------

  function automatic void zero_setpoints();
    preset_mv    = 0;
    reference_mv = 0;
    ramp_mv      = 0;
  endfunction

  // Clamp preset and reference to the ceiling after any button action
  function automatic void clamp_setpoints();
    if (preset_mv > ceiling_mv) preset_mv = ceiling_mv;
    if (reference_mv > ceiling_mv) reference_mv = ceiling_mv;
  endfunction

  // Apply one accepted event and queue the result it must produce
  function automatic void advance_supervisor(input logic [OpWidth-1:0] op,
                                             input logic [CurWidth-1:0] cur);
    logic                running;
    logic                strobe;
    logic                clear;
    int unsigned         next_tick;
    supervisor_outcome_t outcome;
    running = (sup_mode == MODE_RUNNING);
    strobe  = 1'b0;
    clear   = 1'b0;
    case (op)
      OP_CURRENT: begin
        // trip only counts while running, compared greater or equal
        if (running && 32'(cur) >= trip_ma) begin
          sup_mode = MODE_FAULT;
          zero_setpoints();
          clear = 1'b1;
        end
      end
      OP_TICK: begin
        // the tick counter runs in every mode; a divide of 0 or 1 fires each tick
        next_tick = tick_count + 1;
        if (next_tick < tick_div) begin
          tick_count = next_tick;
        end else begin
          tick_count = 0;
          if (running) begin
            // step the ramp toward the reference without overshooting it
            if (ramp_mv < reference_mv) begin
              ramp_mv = ramp_mv + ramp_step;
              if (ramp_mv > reference_mv) ramp_mv = reference_mv;
            end else if (ramp_mv > reference_mv) begin
              ramp_mv = (ramp_mv >= ramp_step) ? ramp_mv - ramp_step : 0;
              if (ramp_mv < reference_mv) ramp_mv = reference_mv;
            end
            strobe = 1'b1;
          end
        end
      end
      OP_MODE: begin
        if (running) begin
          sup_mode = MODE_STANDBY;
          zero_setpoints();
        end else if (sup_mode == MODE_FAULT) begin
          sup_mode = MODE_RUNNING;
          zero_setpoints();
        end else begin
          // start from standby keeps preset and reference
          sup_mode = MODE_RUNNING;
          ramp_mv  = 0;
        end
        clear = 1'b1;
      end
      OP_ADD: begin
        if (running) begin
          preset_mv = preset_mv + preset_step;
          clamp_setpoints();
        end
      end
      OP_REDUCE: begin
        if (running) begin
          preset_mv = (preset_mv >= preset_step) ? preset_mv - preset_step : 0;
          clamp_setpoints();
        end
      end
      OP_SET: begin
        if (running) begin
          reference_mv = preset_mv;
          clamp_setpoints();
        end
      end
      default: ;
    endcase
    preset_mv    = preset_mv & 32'h7FFF;
    reference_mv = reference_mv & 32'h7FFF;
    ramp_mv      = ramp_mv & 32'h7FFF;

    outcome.mode             = sup_mode;
    outcome.preset_mv        = preset_mv[MvWidth-1:0];
    outcome.reference_mv     = reference_mv[MvWidth-1:0];
    outcome.ramp_mv          = ramp_mv[MvWidth-1:0];
    outcome.output_enable    = (sup_mode == MODE_RUNNING);
    outcome.control_strobe   = strobe;
    outcome.clear_controller = clear;
    supervisor_outcomes.push_back(outcome);
  endfunction

  // ------------------------------------------------------------------------
  // Result side: random back-pressure and checking
  // ------------------------------------------------------------------------

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("mismatch on result %0d: %s expected %0d, got %0d",
                 outcomes_checked, name, want, got);
    end
  endfunction

  function automatic void check_outcome(input logic [OutDataWidth-1:0] d);
    supervisor_outcome_t want;
    if (supervisor_outcomes.size() == 0) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("result with nothing outstanding: %h", d);
      return;
    end
    want = supervisor_outcomes.pop_front();
    compare_field("mode",             32'(want.mode),             32'(d[1:0]));
    compare_field("preset_mv",        32'(want.preset_mv),        32'(d[16:2]));
    compare_field("reference_mv",     32'(want.reference_mv),     32'(d[31:17]));
    compare_field("ramp_mv",          32'(want.ramp_mv),          32'(d[46:32]));
    compare_field("output_enable",    32'(want.output_enable),    32'(d[47]));
    compare_field("control_strobe",   32'(want.control_strobe),   32'(d[48]));
    compare_field("clear_controller", 32'(want.clear_controller), 32'(d[49]));
    outcomes_checked++;
    if (want.control_strobe) control_updates++;
    if (want.clear_controller && want.mode == MODE_FAULT) faults_latched++;
  endfunction

  // Sample the result handshake at each edge, then pick the next tready;
  // stalls come in bursts only while idling is allowed
  initial begin
    int unsigned stall;
    stall = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) check_outcome(m_tdata);
      if (stall != 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 7);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Event side
  // ------------------------------------------------------------------------

  // Present one event and hold it until the transaction completes. Valid is
  // left high afterwards so back-to-back events need only one assignment per
  // edge; it drops only for an idle burst or a drain.
  task automatic send_event(input logic [OpWidth-1:0] op, input logic [CurWidth-1:0] cur);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InDataWidth-CurWidth){1'b0}}, cur};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    advance_supervisor(op, cur);
    events_sent++;
  endtask

  // Drop valid and hold until every outstanding result has been checked
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (supervisor_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CfgDataWidth-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TRIP_CURRENT: trip_ma     = value & 32'h3FFF;
      REG_VOUT_MAX:     ceiling_mv  = value & 32'h7FFF;
      REG_PRESET_STEP:  preset_step = value & 32'h3FF;
      REG_RAMP_STEP:    ramp_step   = value & 32'h3FF;
      REG_TICK_DIVIDE:  tick_div    = value & 32'h3F;
      default: ;
    endcase
  endtask

  // Reprogram every register with the block idle
  task automatic configure(input int unsigned trip, input int unsigned vmax,
                           input int unsigned pstep, input int unsigned rstep,
                           input int unsigned tdiv);
    drain_results();
    write_reg(REG_TRIP_CURRENT, trip);
    write_reg(REG_VOUT_MAX, vmax);
    write_reg(REG_PRESET_STEP, pstep);
    write_reg(REG_RAMP_STEP, rstep);
    write_reg(REG_TICK_DIVIDE, tdiv);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Out of reset in standby: spare codes, an ignored button, a full-scale
  // current that must not trip and a tick that must not strobe
  task automatic test_standby_events();
    send_event(OP_SPARE_LO, 14'h2AAA);
    send_event(OP_SPARE_HI, 14'h1555);
    send_event(OP_ADD, '0);
    send_event(OP_CURRENT, 14'h3FFF);
    send_event(OP_TICK, '0);
  endtask

  // Start, saturate at 0, clamp at the ceiling, ramp, trip at exactly the
  // level, ignore buttons in fault, restart and stop
  task automatic test_run_and_latch();
    configure(800, 1500, 1000, 1000, 1);
    send_event(OP_MODE, '0);
    send_event(OP_REDUCE, '0);
    send_event(OP_ADD, '0);
    send_event(OP_ADD, '0);
    send_event(OP_SET, '0);
    send_event(OP_TICK, '0);
    send_event(OP_TICK, '0);
    send_event(OP_CURRENT, 14'd799);
    send_event(OP_CURRENT, 14'd800);
    send_event(OP_ADD, '0);
    send_event(OP_MODE, '0);
    send_event(OP_ADD, '0);
    send_event(OP_SET, '0);
    send_event(OP_MODE, '0);
  endtask

  // Lower the ceiling under a live reference: the ramp keeps following the
  // old reference until a button clamps it, then walks back down to zero
  task automatic test_lowered_ceiling();
    configure(16383, 32767, 1000, 1000, 1);
    send_event(OP_MODE, '0);
    send_event(OP_ADD, '0);
    send_event(OP_ADD, '0);
    send_event(OP_ADD, '0);
    send_event(OP_SET, '0);
    send_event(OP_TICK, '0);
    configure(16383, 1500, 1000, 1000, 1);
    send_event(OP_TICK, '0);
    send_event(OP_REDUCE, '0);
    send_event(OP_TICK, '0);
    send_event(OP_REDUCE, '0);
    send_event(OP_REDUCE, '0);
    send_event(OP_SET, '0);
    send_event(OP_TICK, '0);
    send_event(OP_TICK, '0);
  endtask

  // Mostly well-formed operation: ticks and buttons while running, currents
  // mostly below the trip level, with occasional trips, mode clicks, spare
  // codes and full-pressure drains
  task automatic run_random_events(input int unsigned count);
    int unsigned          pick;
    int unsigned          level;
    logic [OpWidth-1:0]   op;
    logic [CurWidth-1:0]  cur;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (sup_mode != MODE_RUNNING && pick < 35) op = OP_MODE;
      else if (pick < 30) op = OP_TICK;
      else if (pick < 42) op = OP_CURRENT;
      else if (pick < 64) op = OP_ADD;
      else if (pick < 74) op = OP_REDUCE;
      else if (pick < 86) op = OP_SET;
      else if (pick < 88) op = OP_MODE;
      else if (pick < 90) op = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
      else op = OP_TICK;

      level = $urandom_range(0, 19);
      if (level < 17 && trip_ma > 0) cur = CurWidth'($urandom_range(0, trip_ma - 1));
      else if (level == 17) cur = trip_ma[CurWidth-1:0];
      else cur = CurWidth'($urandom_range(0, 16383));

      send_event(op, cur);
      // no pauses once the final full-rate stretch has begun
      if (idle_on && $urandom_range(0, 99) == 0) drain_results();
    end
  endtask

  // Walk through reset values, both extremes, zero steps and random settings
  task automatic test_random_phases();
    configure(32'(TripResetMa), 32'(VoutMaxResetMv), 32'(PresetStepReset),
              32'(RampStepReset), 32'(TickDivideReset));
    run_random_events(230);
    configure(16383, 32767, 1000, 1000, 63);
    run_random_events(180);
    configure(0, 0, 1, 1, 1);
    run_random_events(120);
    configure($urandom_range(300, 3000), $urandom_range(1000, 32767),
              $urandom_range(1, 1000), $urandom_range(1, 1000), $urandom_range(1, 8));
    run_random_events(230);
    configure(1500, 9000, 0, 1000, 0);
    run_random_events(120);
    configure($urandom_range(300, 3000), $urandom_range(1000, 32767), 1000, 0, 2);
    run_random_events(120);
    // final stretch at full rate: no gaps, no stalls
    configure($urandom_range(300, 3000), $urandom_range(1000, 32767),
              $urandom_range(1, 1000), $urandom_range(1, 1000), $urandom_range(1, 8));
    idle_on = 1'b0;
    run_random_events(260);
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    idle_on   = 1'b1;
    errors           = 0;
    events_sent      = 0;
    outcomes_checked = 0;
    faults_latched   = 0;
    control_updates  = 0;
    settings_used    = 1;

    // register and state values out of reset
    trip_ma      = 32'(TripResetMa);
    ceiling_mv   = 32'(VoutMaxResetMv);
    preset_step  = 32'(PresetStepReset);
    ramp_step    = 32'(RampStepReset);
    tick_div     = 32'(TickDivideReset);
    sup_mode     = MODE_STANDBY;
    preset_mv    = 0;
    reference_mv = 0;
    ramp_mv      = 0;
    tick_count   = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_standby_events();
    test_run_and_latch();
    test_lowered_ceiling();
    test_random_phases();

    // let the last results out, then keep watching for strays
    drain_results();
    repeat (8) @(posedge clk);

    $display("covered %0d events under %0d register settings, %0d results checked",
             events_sent, settings_used, outcomes_checked);
    $display("saw %0d overcurrent latches and %0d control updates",
             faults_latched, control_updates);
    if (errors == 0 && supervisor_outcomes.size() == 0)
      $display("[converter_supervisor_soft_start_core] OK");
    else
      $display("[converter_supervisor_soft_start_core] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cnv_ss_pkg.sv
rtl/converter_supervisor_soft_start_core.sv
bench/converter_supervisor_soft_start_core_test.sv
